// ===== rtl/mcpd_pkg.sv =====
// Shared types and constants for the multi-channel plug debouncer.
package mcpd_pkg;

    localparam int unsigned NUM_CHANNELS_DEF = 8;
    localparam int unsigned CH_W             = 3;
    localparam int unsigned REG_W            = 8;
    localparam int unsigned CFG_IDX_W        = 2;

    localparam logic [REG_W-1:0] CNT_MAX       = 8'hFF;
    localparam logic [REG_W-1:0] RELEASE_RESET = 8'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LEVELS  = 2'd0,
        CFG_CHANNEL_ENABLE = 2'd1,
        CFG_RELEASE_COUNT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [REG_W-1:0] active_levels;
        logic [REG_W-1:0] channel_enable;
        logic [REG_W-1:0] release_count;
    } t_cfg;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic            level;
        logic            skip;
    } t_sample;

    typedef struct packed {
        logic            hit;
        logic [CH_W-1:0] channel;
        logic            plugged;
    } t_event;

endpackage

// ===== rtl/mcpd_update.sv =====
// Per-channel presence state and the read-modify-write for one sample.
module mcpd_update #(
    parameter int unsigned NUM_CHANNELS = mcpd_pkg::NUM_CHANNELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mcpd_pkg::t_cfg    i_cfg,
    input  mcpd_pkg::t_sample i_smp,
    input  logic             i_commit,
    output mcpd_pkg::t_event  o_evt
);

    localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [mcpd_pkg::CH_W:0] NCH = (mcpd_pkg::CH_W + 1)'(NUM_CHANNELS);

    logic [mcpd_pkg::REG_W-1:0] r_cnt [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]    r_present;

    logic                       in_range;
    logic                       live;
    logic [IDX_W-1:0]           idx;
    logic                       match;
    logic [mcpd_pkg::REG_W-1:0] cnt;
    logic [mcpd_pkg::REG_W-1:0] cnt_inc;
    logic                       present;
    logic                       plug;
    logic                       drop;

    always_comb begin
        in_range = ({1'b0, i_smp.channel} < NCH);
        live     = !i_smp.skip && in_range && i_cfg.channel_enable[i_smp.channel];
        idx      = i_smp.channel[IDX_W-1:0];
        match    = (i_smp.level == i_cfg.active_levels[i_smp.channel]);
        cnt      = r_cnt[idx];
        present  = r_present[idx];
        cnt_inc  = (cnt == mcpd_pkg::CNT_MAX) ? cnt : cnt + 1'b1;
        plug     = live && match && !present;
        drop     = live && !match && present && (cnt_inc > i_cfg.release_count);

        o_evt.hit     = plug || drop;
        o_evt.channel = i_smp.channel;
        o_evt.plugged = plug;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_commit && live) begin
            // clear on match, count up (saturating) otherwise
            r_cnt[idx] <= match ? '0 : cnt_inc;
            if (plug) begin
                r_present[idx] <= 1'b1;
            end else if (drop) begin
                r_present[idx] <= 1'b0;
            end
        end
    end

    // a committed plug-in leaves the channel present, a removal leaves it absent
    a_plug_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && plug |=> r_present[$past(idx)])
        else $error("plug-in did not set presence");
    a_drop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && drop |=> !r_present[$past(idx)])
        else $error("removal did not clear presence");
    a_match_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && live && match |=> r_cnt[$past(idx)] == '0)
        else $error("matching sample did not clear counter");

endmodule

// ===== rtl/multi_channel_plug_debouncer.sv =====
// Top level of the multi-channel plug debouncer.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one pin sample per transaction:
//   i_channel, i_level and i_skip. Output channel (o_valid / i_ready) carries
//   presence events: o_event_channel and o_plugged (1 plug-in, 0 removal).
//   A sample yields at most one event; samples that change no presence yield
//   no transaction at all.
//   Configuration: write i_cfg_wdata to register i_cfg_idx while i_cfg_we is
//   high (0 active levels, 1 channel enable, 2 release count). Write only
//   while the block is idle.
// Timing:
//   One sample is accepted every cycle while o_ready is high. The channel
//   state read-modify-write runs on the sample in the input register and its
//   event loads the output register as that sample advances, raising o_valid.
//   When the receiver stalls, the event is held in the output register and
//   the input register holds its sample; o_ready drops only while both are
//   full and i_ready is low.
// Reset:
//   Synchronous, active low. Clears all presence flags and mismatch counters,
//   zeroes active levels and enables, and loads the release count with 6.
module multi_channel_plug_debouncer #(
    parameter int unsigned NUM_CHANNELS = mcpd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [mcpd_pkg::CH_W-1:0]      i_channel,
    input  logic                           i_level,
    input  logic                           i_skip,
    // event channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [mcpd_pkg::CH_W-1:0]      o_event_channel,
    output logic                           o_plugged,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [mcpd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mcpd_pkg::REG_W-1:0]     i_cfg_wdata
);

    mcpd_pkg::t_cfg    r_cfg;
    mcpd_pkg::t_sample r_stg;
    logic              r_stg_vld;
    logic              r_out_vld;
    logic [mcpd_pkg::CH_W-1:0] r_out_ch;
    logic              r_out_plugged;

    logic              stg_adv;
    logic              n_out_vld;
    mcpd_pkg::t_event  evt;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_levels  <= '0;
            r_cfg.channel_enable <= '0;
            r_cfg.release_count  <= mcpd_pkg::RELEASE_RESET;
        end else if (i_cfg_we) begin
            unique case (mcpd_pkg::t_cfg_idx'(i_cfg_idx))
                mcpd_pkg::CFG_ACTIVE_LEVELS:  r_cfg.active_levels  <= i_cfg_wdata;
                mcpd_pkg::CFG_CHANNEL_ENABLE: r_cfg.channel_enable <= i_cfg_wdata;
                mcpd_pkg::CFG_RELEASE_COUNT:  r_cfg.release_count  <= i_cfg_wdata;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // Advance the staged sample whenever the output register is free or
    // being emptied this cycle; the state update commits on the same edge.
    assign stg_adv = r_stg_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_stg_vld || stg_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
        end else if (o_ready) begin
            r_stg_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stg.channel <= i_channel;
            r_stg.level   <= i_level;
            r_stg.skip    <= i_skip;
        end
    end

    mcpd_update #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_smp    (r_stg),
        .i_commit (stg_adv),
        .o_evt    (evt)
    );

    // Output register: load on advance, empty when taken.
    always_comb begin
        n_out_vld = r_out_vld;
        if (stg_adv) begin
            n_out_vld = evt.hit;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_adv && evt.hit) begin
            r_out_ch      <= evt.channel;
            r_out_plugged <= evt.plugged;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_event_channel = r_out_ch;
    assign o_plugged       = r_out_plugged;

    // a staged sample that cannot advance must stay put
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_vld && !stg_adv |=> r_stg_vld && $stable(r_stg))
        else $error("staged sample lost while stalled");
    // a new event only comes from an advancing sample
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld ##1 r_out_vld |-> $past(stg_adv))
        else $error("event appeared without an advancing sample");
    // an unaccepted event is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_ready |=> r_out_vld && $stable(r_out_ch)
                                  && $stable(r_out_plugged))
        else $error("pending event overwritten");

endmodule
